// ===== sv/atp_pkg.sv =====
package atp_pkg;

  typedef enum logic [1:0] {
    CMD_MEASURE = 2'd0,
    CMD_CAL     = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_AXES    = 2'd0,
    MODE_RADIANS = 2'd1,
    MODE_DEGREES = 2'd2,
    MODE_ALT     = 2'd3
  } mode_e;

  localparam logic [0:0] REG_MODE      = 1'b0;
  localparam logic [0:0] REG_THRESHOLD = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CORR,
    ST_SQ,
    ST_MAG,
    ST_DEN,
    ST_ATAN,
    ST_ANG,
    ST_CAL,
    ST_DIV,
    ST_OUT
  } state_e;

  // Q16 atan table for the CORDIC
  function automatic logic [15:0] atan_q16(input logic [3:0] i);
    logic [15:0] r;
    case (i)
      4'd0:  r = 16'd51472;
      4'd1:  r = 16'd30386;
      4'd2:  r = 16'd16055;
      4'd3:  r = 16'd8150;
      4'd4:  r = 16'd4091;
      4'd5:  r = 16'd2047;
      4'd6:  r = 16'd1024;
      4'd7:  r = 16'd512;
      4'd8:  r = 16'd256;
      4'd9:  r = 16'd128;
      4'd10: r = 16'd64;
      4'd11: r = 16'd32;
      4'd12: r = 16'd16;
      4'd13: r = 16'd8;
      4'd14: r = 16'd4;
      default: r = 16'd2;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
    logic signed [15:0] r;
    if (v > 34'sd32767) r = 16'sh7fff;
    else if (v < -34'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

// ===== sv/atp_sqrt.sv =====
// Bit-pair serial rounded square root of a 34-bit radicand, one result bit a cycle.
module atp_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [33:0] rad_i,
  output logic        busy_o,
  output logic [16:0] root_o
);
  logic [33:0] rad_q, rad_d;
  logic [18:0] rem_q, rem_d;
  logic [16:0] res_q, res_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [18:0] trial;

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    res_d  = res_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[16:0], rad_q[33:32]} - {res_q[16:0], 2'b01};
    if (start_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      res_d  = '0;
      cnt_d  = 5'd17;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[31:0], 2'b00};
      if (!trial[18]) begin
        rem_d = trial;
        res_d = {res_q[15:0], 1'b1};
      end else begin
        rem_d = {rem_q[16:0], rad_q[33:32]};
        res_d = {res_q[15:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q <= rad_d;
    rem_q <= rem_d;
    res_q <= res_d;
  end

  // remainder above root means round up
  assign busy_o = busy_q;
  assign root_o = (rem_q > {2'b00, res_q}) ? res_q + 17'd1 : res_q;
endmodule

// ===== sv/atp_cordic.sv =====
// Vectoring CORDIC, one rotation a cycle, 16 rotations; Q16 angle out.
module atp_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [15:0] num_i,
  input  logic [16:0]        den_i,
  output logic               busy_o,
  output logic signed [19:0] angle_o
);
  logic signed [35:0] x_q, x_d, y_q, y_d;
  logic signed [19:0] z_q, z_d;
  logic [3:0]  i_q, i_d;
  logic        busy_q, busy_d, zero_q, zero_d;
  logic signed [35:0] dx, dy;
  logic signed [19:0] a;

  function automatic logic [15:0] atan_lookup(input logic [3:0] k);
    return atp_pkg::atan_q16(k);
  endfunction

  always_comb begin
    x_d = x_q; y_d = y_q; z_d = z_q; i_d = i_q; busy_d = busy_q; zero_d = zero_q;
    dx = y_q >>> i_q;
    dy = x_q >>> i_q;
    a  = 20'(atan_lookup(i_q));
    if (start_i) begin
      x_d = {3'b000, den_i, 16'd0};
      y_d = {{4{num_i[15]}}, num_i, 16'd0};
      z_d = '0; i_d = '0; busy_d = 1'b1;
      zero_d = (num_i == 16'sd0);
    end else if (busy_q) begin
      if (y_q > 36'sd0) begin
        x_d = x_q + dx; y_d = y_q - dy; z_d = z_q + a;
      end else begin
        x_d = x_q - dx; y_d = y_q + dy; z_d = z_q - a;
      end
      i_d = i_q + 4'd1;
      if (i_q == 4'd15) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      i_q    <= '0;
    end else begin
      busy_q <= busy_d;
      i_q    <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d; zero_q <= zero_d;
  end

  assign busy_o  = busy_q;
  assign angle_o = zero_q ? 20'sd0 : z_q;
endmodule

// ===== sv/atp_div.sv =====
// Restoring divider, one quotient bit a cycle; rounds half away from zero.
module atp_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [26:0] num_i,
  input  logic [9:0]         den_i,
  output logic               busy_o,
  output logic signed [15:0] neg_mean_o
);
  logic [27:0] n_q, n_d;
  logic [10:0] r_q, r_d;
  logic [27:0] qt_q, qt_d;
  logic [9:0]  den_q, den_d;
  logic        neg_q, neg_d, busy_q, busy_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [27:0] mag;
  logic [10:0] sh;
  logic signed [33:0] m;

  always_comb begin
    n_d = n_q; r_d = r_q; qt_d = qt_q; den_d = den_q; neg_d = neg_q;
    busy_d = busy_q; cnt_d = cnt_q;
    mag = num_i[26] ? 28'(-{num_i[26], num_i}) : {1'b0, num_i};
    sh  = {r_q[9:0], n_q[27]};
    if (start_i) begin
      n_d = mag + 28'({1'b0, den_i} >> 1);
      r_d = '0; qt_d = '0; den_d = den_i; neg_d = num_i[26];
      cnt_d = 5'd28; busy_d = 1'b1;
    end else if (busy_q) begin
      n_d = {n_q[26:0], 1'b0};
      if (sh >= {1'b0, den_q}) begin
        r_d = sh - {1'b0, den_q}; qt_d = {qt_q[26:0], 1'b1};
      end else begin
        r_d = sh; qt_d = {qt_q[26:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) busy_d = 1'b0;
    end
    m = neg_q ? 34'($signed({6'd0, qt_q})) : -34'($signed({6'd0, qt_q}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; r_q <= r_d; qt_q <= qt_d; den_q <= den_d; neg_q <= neg_d;
  end

  assign busy_o     = busy_q;
  assign neg_mean_o = atp_pkg::sat16(m);
endmodule

// ===== sv/accel_tilt_processor_core.sv =====
// Accelerometer tilt processor.
// Measure in axes and alt modes takes the magnitude root; tilt modes add,
// per axis, a denominator root, a CORDIC run and the angle scaling. A
// calibration finish takes three divides; other calibration words, clear
// and unused codes go straight to the output step. One word is in flight;
// the next word is taken only once the result has been accepted.
// Reset (rst_ni low, async): offsets, sums, count and flag zero, view mode 0,
// flat_threshold 512.
module accel_tilt_processor_core #(
  parameter int CAL_SAMPLES = 30
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // sample_x, sample_y, sample_z
  input  logic [1:0]  s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // value_x, value_y, value_z, magnitude,
                                      // indicators, offsets_custom, calibration_done
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [14:0] cfg_data_i
);
  localparam logic [9:0] CalN = 10'(CAL_SAMPLES);

  atp_pkg::state_e st_q, st_d;
  logic [1:0]  mode_q;
  logic [14:0] thr_q;
  logic signed [15:0] off_q [3];
  logic signed [26:0] sum_q [3];
  logic [9:0]  cnt_q;
  logic        flag_q;
  // per-item working registers
  logic signed [15:0] c_q [3];
  logic [31:0] sq_q [3];
  logic [16:0] mag_q, den_q;
  logic [1:0]  ax_q;            // axis under work
  logic signed [15:0] vx_q, vy_q;
  logic [4:0]  ind_q;
  logic        done_q;
  logic [1:0]  cmd_q;
  logic [71:0] out_q;
  logic        ovalid_q;
  // unit handshakes
  logic        sq_start, sq_busy, co_start, co_busy, dv_start, dv_busy;
  logic [33:0] rad;
  logic [16:0] root;
  logic signed [19:0] ang;
  logic signed [15:0] nm;
  logic [1:0]  step_q;          // sub-step within a state
  logic signed [33:0] angv;
  logic signed [33:0] prod;
  logic signed [33:0] pabs, pdiv;
  logic [15:0] degb, degb_q;    // |angle * 573| + half, in units of 1024
  logic        deg_neg_q;
  logic [31:0] degq;
  logic signed [33:0] degm;
  logic signed [15:0] angsat;

  assign s_axis_tready = (st_q == atp_pkg::ST_IDLE) && !ovalid_q;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = out_q;

  // radicand selection
  always_comb begin
    case (ax_q)
      2'd0:    rad = {2'b00, sq_q[1]} + {2'b00, sq_q[2]};
      2'd1:    rad = {2'b00, sq_q[0]} + {2'b00, sq_q[2]};
      default: rad = {2'b00, sq_q[0]} + {2'b00, sq_q[1]} + {2'b00, sq_q[2]};
    endcase
  end

  atp_sqrt u_sqrt (.clk_i, .rst_ni, .start_i(sq_start), .rad_i(rad),
                   .busy_o(sq_busy), .root_o(root));
  atp_cordic u_cordic (.clk_i, .rst_ni, .start_i(co_start),
                       .num_i(ax_q[0] ? c_q[1] : c_q[0]), .den_i(den_q),
                       .busy_o(co_busy), .angle_o(ang));
  atp_div u_div (.clk_i, .rst_ni, .start_i(dv_start),
                 .num_i(sum_q[ax_q]), .den_i(cnt_q),
                 .busy_o(dv_busy), .neg_mean_o(nm));

  // angle formatting: radians Q2.13 or 1/128 degree (x573/5120, half away).
  // Degrees take two steps: first |p| + 2560 scaled down by 1024 is held,
  // then /5 by reciprocal multiply (exact below 2^16) and the sign is restored.
  always_comb begin
    angv = 34'(ang);
    prod = angv * 34'sd573;
    pabs = (prod < 34'sd0) ? -prod : prod;
    pdiv = pabs + 34'sd2560;
    degb = 16'(pdiv >>> 10);
    degq = {16'd0, degb_q} * 32'd52429;
    degm = $signed({20'd0, degq[31:18]});
    if (mode_q == atp_pkg::MODE_RADIANS) angsat = atp_pkg::sat16((angv + 34'sd4) >>> 3);
    else angsat = atp_pkg::sat16(deg_neg_q ? -degm : degm);
  end

  always_comb begin
    st_d = st_q;
    sq_start = 1'b0;
    co_start = 1'b0;
    dv_start = 1'b0;
    case (st_q)
      atp_pkg::ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
        case (atp_pkg::cmd_e'(s_axis_tuser))
          atp_pkg::CMD_MEASURE: st_d = atp_pkg::ST_CORR;
          atp_pkg::CMD_CAL:     st_d = atp_pkg::ST_CAL;
          default:              st_d = atp_pkg::ST_OUT;
        endcase
      end
      atp_pkg::ST_CORR: st_d = atp_pkg::ST_SQ;
      atp_pkg::ST_SQ: st_d = atp_pkg::ST_MAG;
      // squares are registered by now; root of all three
      atp_pkg::ST_MAG: begin
        if (step_q == 2'd0) sq_start = 1'b1;
        else if (!sq_busy && step_q == 2'd2) begin
          if (mode_q == atp_pkg::MODE_RADIANS || mode_q == atp_pkg::MODE_DEGREES) begin
            st_d = atp_pkg::ST_DEN;
          end else begin
            st_d = atp_pkg::ST_OUT;
          end
        end
      end
      atp_pkg::ST_DEN: begin
        if (step_q == 2'd0) sq_start = 1'b1;
        else if (!sq_busy && step_q == 2'd2) st_d = atp_pkg::ST_ATAN;
      end
      atp_pkg::ST_ATAN: begin
        if (step_q == 2'd0) co_start = 1'b1;
        else if (!co_busy && step_q == 2'd2) st_d = atp_pkg::ST_ANG;
      end
      atp_pkg::ST_ANG: if (step_q != 2'd0) begin
        st_d = ax_q[0] ? atp_pkg::ST_OUT : atp_pkg::ST_DEN;
      end
      atp_pkg::ST_CAL: begin
        if (cnt_q >= CalN || cnt_q == 10'd1023) begin
          st_d = atp_pkg::ST_DIV;
        end else begin
          st_d = atp_pkg::ST_OUT;
        end
      end
      atp_pkg::ST_DIV: begin
        if (step_q == 2'd0) dv_start = 1'b1;
        else if (!dv_busy && step_q == 2'd2 && ax_q == 2'd2) st_d = atp_pkg::ST_OUT;
      end
      atp_pkg::ST_OUT: st_d = atp_pkg::ST_IDLE;
      default: st_d = atp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= atp_pkg::ST_IDLE;
      mode_q   <= atp_pkg::MODE_AXES;
      thr_q    <= 15'd512;
      off_q    <= '{default: '0};
      sum_q    <= '{default: '0};
      cnt_q    <= '0;
      flag_q   <= 1'b0;
      ovalid_q <= 1'b0;
      step_q   <= '0;
      ax_q     <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == atp_pkg::REG_MODE) mode_q <= cfg_data_i[1:0];
        else thr_q <= cfg_data_i;
      end
      if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
      case (st_q)
        atp_pkg::ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          cmd_q <= s_axis_tuser;
          for (int k = 0; k < 3; k++) c_q[k] <= s_axis_tdata[16*k +: 16];
          done_q <= 1'b0; vx_q <= '0; vy_q <= '0; ind_q <= '0; mag_q <= '0;
          ax_q <= 2'd2; step_q <= '0;
          if (s_axis_tuser == atp_pkg::CMD_CLEAR) begin
            off_q <= '{default: '0}; sum_q <= '{default: '0};
            cnt_q <= '0; flag_q <= 1'b0;
          end else if (s_axis_tuser == atp_pkg::CMD_CAL) begin
            for (int k = 0; k < 3; k++)
              sum_q[k] <= sum_q[k] + 27'(signed'(s_axis_tdata[16*k +: 16]));
            cnt_q <= cnt_q + 10'd1;
          end
        end
        atp_pkg::ST_CORR: begin
          for (int k = 0; k < 3; k++)
            c_q[k] <= atp_pkg::sat16(34'(c_q[k]) + 34'(off_q[k]));
        end
        atp_pkg::ST_SQ: begin
          for (int k = 0; k < 3; k++) sq_q[k] <= 32'(c_q[k]) * 32'(c_q[k]);
          vx_q <= c_q[0]; vy_q <= c_q[1];
          // right/left from X, front/back from Y
          if ((c_q[0] < 0 ? -(17'(c_q[0])) : 17'(c_q[0])) > {2'b00, thr_q}) begin
            ind_q[1] <= c_q[0] > 0;
            ind_q[3] <= c_q[0] < 0;
          end
          if ((c_q[1] < 0 ? -(17'(c_q[1])) : 17'(c_q[1])) > {2'b00, thr_q}) begin
            ind_q[4] <= c_q[1] > 0;
            ind_q[2] <= c_q[1] < 0;
          end
        end
        atp_pkg::ST_MAG: begin
          if (step_q == 2'd0) step_q <= 2'd1;
          else if (step_q == 2'd1) step_q <= 2'd2;
          else if (!sq_busy) begin
            mag_q <= root;
            if (ind_q == 5'd0) ind_q <= 5'd1;
            ax_q <= 2'd0; step_q <= '0;
          end
        end
        atp_pkg::ST_DEN: begin
          if (step_q == 2'd0) step_q <= 2'd1;
          else if (step_q == 2'd1) step_q <= 2'd2;
          else if (!sq_busy) begin den_q <= root; step_q <= '0; end
        end
        atp_pkg::ST_ATAN: begin
          if (step_q == 2'd0) step_q <= 2'd1;
          else if (step_q == 2'd1) step_q <= 2'd2;
          else if (!co_busy) step_q <= '0;
        end
        atp_pkg::ST_ANG: begin
          if (step_q == 2'd0) begin
            degb_q <= degb; deg_neg_q <= prod < 34'sd0; step_q <= 2'd1;
          end else begin
            if (ax_q[0]) vy_q <= angsat;
            else vx_q <= angsat;
            ax_q <= 2'd1; step_q <= '0;
          end
        end
        atp_pkg::ST_CAL: begin ax_q <= 2'd0; step_q <= '0; end
        atp_pkg::ST_DIV: begin
          if (step_q == 2'd0) step_q <= 2'd1;
          else if (step_q == 2'd1) step_q <= 2'd2;
          else if (!dv_busy) begin
            off_q[ax_q] <= nm;
            step_q <= '0;
            if (ax_q == 2'd2) begin
              sum_q <= '{default: '0}; cnt_q <= '0; flag_q <= 1'b1; done_q <= 1'b1;
            end else ax_q <= ax_q + 2'd1;
          end
        end
        atp_pkg::ST_OUT: begin
          ovalid_q <= 1'b1;
          if (cmd_q == atp_pkg::CMD_MEASURE)
            out_q <= {1'b0, done_q, flag_q, ind_q, mag_q[15:0], c_q[2], vy_q, vx_q};
          else
            out_q <= {1'b0, done_q, flag_q, 69'd0};
        end
        default: ;
      endcase
    end
  end

  // a result is only offered after the sequencer passes its output step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(st_q == atp_pkg::ST_OUT)) else $error("stray result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid) else $error("accept with pending result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == atp_pkg::ST_OUT && done_q) |-> flag_q) else $error("done without flag");
endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // no accepted word for this many cycles ends the run; the longest correct
  // gap is the receiver hold-off in test_backpressure plus the block latency
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_PAUSE    = 200;
  localparam int CAL_COUNT      = 30;

  typedef struct packed {
    logic              done;
    logic              cust;
    logic [4:0]        ind;
    logic [15:0]       mag;
    logic signed [15:0] vz;
    logic signed [15:0] vy;
    logic signed [15:0] vx;
  } tilt_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;     // sample_x, sample_y, sample_z
  logic [1:0]  s_tuser = '0;     // cmd
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;          // value_x, value_y, value_z, magnitude, indicators,
                                 // offsets_custom, calibration_done
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = '0;
  logic [14:0] cfg_data = '0;

  accel_tilt_processor_core #(.CAL_SAMPLES(CAL_COUNT)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready),
    .s_axis_tdata(s_tdata), .s_axis_tuser(s_tuser),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready), .m_axis_tdata(m_tdata),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always #1 clk_i = ~clk_i;

  // ---------------- predictor state ----------------
  atp_pkg::mode_e p_mode;
  int          p_thresh;
  int          p_off_x, p_off_y, p_off_z;
  int          p_sum_x, p_sum_y, p_sum_z;
  int          p_count;
  logic        p_custom;

  tilt_res_t   pending_q[$];
  int          errors = 0;
  int          words_in = 0, words_out = 0, cal_finishes = 0;
  int          src_idle_pct = 0, snk_idle_pct = 0;
  int          hold_left = 0;
  int          idle_cnt = 0;

  function automatic int clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  // integer root, rounded to nearest
  function automatic longint root_rnd(longint unsigned s);
    longint unsigned res, bitv, n;
    res = 0; bitv = 64'd1 << 62; n = s;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    if (s - res * res > res) res++;
    return longint'(res);
  endfunction

  function automatic longint angle_tab(int i);
    longint t[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                      256, 128, 64, 32, 16, 8, 4, 2};
    return t[i];
  endfunction

  // vectoring CORDIC, Q16 radians; >>> on signed longint is a floor shift
  function automatic longint atan2_q16(int num, longint den);
    longint x, y, z, dx, dy;
    x = den * 65536; y = longint'(num) * 65536; z = 0;
    if (num == 0) return 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i; dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += angle_tab(i);
      end else begin
        x -= dx; y += dy; z -= angle_tab(i);
      end
    end
    return z;
  endfunction

  function automatic int angle_fmt(longint z, atp_pkg::mode_e m);
    longint p, q;
    if (m == atp_pkg::MODE_RADIANS) return clip16((z + 4) >>> 3);
    p = z * 573;
    q = (p >= 0) ? (p + 2560) / 5120 : -((-p + 2560) / 5120);
    return clip16(q);
  endfunction

  function automatic int offset_from(int sum, int cnt);
    longint m;
    m = (sum >= 0) ? (longint'(sum) + cnt / 2) / cnt : -((-longint'(sum) + cnt / 2) / cnt);
    return clip16(-m);
  endfunction

  // expected result of one word; updates the predictor state
  function automatic tilt_res_t tilt_predict(atp_pkg::cmd_e cmd, int sx, int sy, int sz);
    tilt_res_t r;
    int cx, cy, cz;
    longint x2, y2, z2;
    r = '0;
    case (cmd)
      atp_pkg::CMD_MEASURE: begin
        cx = clip16(sx + p_off_x);
        cy = clip16(sy + p_off_y);
        cz = clip16(sz + p_off_z);
        x2 = longint'(cx) * cx; y2 = longint'(cy) * cy; z2 = longint'(cz) * cz;
        if ((cx < 0 ? -cx : cx) > p_thresh) r.ind |= (cx > 0) ? 5'h02 : 5'h08;
        if ((cy < 0 ? -cy : cy) > p_thresh) r.ind |= (cy > 0) ? 5'h10 : 5'h04;
        if (r.ind == 0) r.ind = 5'h01;
        r.mag = 16'(root_rnd(x2 + y2 + z2));
        r.vz = 16'(cz);
        if (p_mode == atp_pkg::MODE_RADIANS || p_mode == atp_pkg::MODE_DEGREES) begin
          r.vx = 16'(angle_fmt(atan2_q16(cx, root_rnd(y2 + z2)), p_mode));
          r.vy = 16'(angle_fmt(atan2_q16(cy, root_rnd(x2 + z2)), p_mode));
        end else begin
          r.vx = 16'(cx);
          r.vy = 16'(cy);
        end
      end
      atp_pkg::CMD_CAL: begin
        p_sum_x += sx; p_sum_y += sy; p_sum_z += sz;
        p_count++;
        if (p_count >= CAL_COUNT || p_count >= 1023) begin
          p_off_x = offset_from(p_sum_x, p_count);
          p_off_y = offset_from(p_sum_y, p_count);
          p_off_z = offset_from(p_sum_z, p_count);
          p_custom = 1'b1;
          p_sum_x = 0; p_sum_y = 0; p_sum_z = 0; p_count = 0;
          r.done = 1'b1;
        end
      end
      atp_pkg::CMD_CLEAR: begin
        p_off_x = 0; p_off_y = 0; p_off_z = 0; p_custom = 1'b0;
        p_sum_x = 0; p_sum_y = 0; p_sum_z = 0; p_count = 0;
      end
      default: ;  // unused code: nothing changes
    endcase
    r.cust = p_custom;
    return r;
  endfunction

  // ---------------- drivers ----------------
  task automatic send_word(atp_pkg::cmd_e cmd, logic signed [15:0] x,
                           logic signed [15:0] y, logic signed [15:0] z);
    int gap;
    gap = ($urandom_range(99) < src_idle_pct) ? $urandom_range(1, 4) : 0;
    repeat (gap) @(negedge clk_i);
    s_tvalid = 1'b1;
    s_tdata  = {z, y, x};
    s_tuser  = cmd;
    do @(posedge clk_i); while (!s_tready);
    pending_q.push_back(tilt_predict(cmd, x, y, z));
    words_in++;
    @(negedge clk_i);
    s_tvalid = 1'b0;
  endtask

  // every word yields a result, so an empty queue plus the latency means idle
  task automatic drain();
    wait (pending_q.size() == 0);
    repeat (DRAIN_PAUSE) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [14:0] val);
    drain();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk_i); while (!cfg_ready);
    if (idx == atp_pkg::REG_MODE) p_mode = atp_pkg::mode_e'(val[1:0]);
    else p_thresh = val;
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  // ---------------- receiver and checker ----------------
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_tready = 1'b0;
      hold_left--;
    end else begin
      m_tready = ($urandom_range(99) >= snk_idle_pct);
    end
  end

  task automatic report_mismatch(string fld, int got, int want);
    $display("mismatch on word %0d: %s got %0d expected %0d", words_out, fld, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    tilt_res_t got, want;
    if (rst_ni && m_tvalid && m_tready) begin
      got = tilt_res_t'(m_tdata[70:0]);
      if (pending_q.size() == 0) begin
        $display("unexpected result word %0d", words_out);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (got.vx != want.vx) report_mismatch("value_x", got.vx, want.vx);
        if (got.vy != want.vy) report_mismatch("value_y", got.vy, want.vy);
        if (got.vz != want.vz) report_mismatch("value_z", got.vz, want.vz);
        if (got.mag != want.mag) report_mismatch("magnitude", got.mag, want.mag);
        if (got.ind != want.ind) report_mismatch("indicators", got.ind, want.ind);
        if (got.cust != want.cust) report_mismatch("offsets_custom", got.cust, want.cust);
        if (got.done != want.done) report_mismatch("calibration_done", got.done, want.done);
        if (want.done) cal_finishes++;
      end
      words_out++;
    end
  end

  // watchdog: any accepted word restarts the count
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  // ---------------- tests ----------------
  function automatic logic signed [15:0] pick16();
    logic signed [15:0] ext[5] = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd1};
    if ($urandom_range(7) == 0) return ext[$urandom_range(4)];
    return 16'($urandom);
  endfunction

  // extremes, default settings, unused code and clear
  task automatic test_directed();
    send_word(atp_pkg::CMD_MEASURE, 16'sd0, 16'sd0, 16'sd0);
    send_word(atp_pkg::CMD_MEASURE, 16'sd32767, 16'sd32767, 16'sd32767);
    send_word(atp_pkg::CMD_MEASURE, -16'sd32768, -16'sd32768, -16'sd32768);
    send_word(atp_pkg::CMD_MEASURE, 16'sd512, -16'sd512, 16'sd1024);
    send_word(atp_pkg::CMD_MEASURE, 16'sd513, -16'sd513, 16'sd0);
    send_word(atp_pkg::CMD_MEASURE, -16'sd600, 16'sd600, -16'sd1);
    send_word(atp_pkg::CMD_NONE, 16'sd1234, -16'sd1234, 16'sd99);
    send_word(atp_pkg::CMD_CLEAR, -16'sd1, -16'sd1, -16'sd1);
    // measure in each display mode, extremes of threshold
    for (int m = 0; m < 4; m++) begin
      write_reg(atp_pkg::REG_MODE, 15'(m));
      write_reg(atp_pkg::REG_THRESHOLD, (m % 2) ? 15'h7fff : 15'd0);
      send_word(atp_pkg::CMD_MEASURE, 16'sd10000, -16'sd3000, 16'sd10240);
      send_word(atp_pkg::CMD_MEASURE, -16'sd32768, 16'sd0, 16'sd0);
      send_word(atp_pkg::CMD_MEASURE, 16'sd0, 16'sd32767, -16'sd1);
    end
  endtask

  // one calibration run; measure words are mixed in, clear may abort it
  task automatic cal_run(bit may_clear);
    logic signed [15:0] bx, by, bz;
    int n;
    bx = pick16(); by = pick16(); bz = pick16();
    n = 0;
    while (n < CAL_COUNT) begin
      if ($urandom_range(4) == 0) send_word(atp_pkg::CMD_MEASURE, pick16(), pick16(), pick16());
      else begin
        send_word(atp_pkg::CMD_CAL, 16'(clip16(bx + $signed($urandom_range(64)) - 32)),
                  16'(clip16(by + $signed($urandom_range(64)) - 32)),
                  16'(clip16(bz + $signed($urandom_range(64)) - 32)));
        n++;
      end
      if (may_clear && $urandom_range(39) == 0) begin
        send_word(atp_pkg::CMD_CLEAR, pick16(), pick16(), pick16());
        return;
      end
    end
  endtask

  task automatic test_random(int count);
    int r, start;
    start = words_in;
    while (words_in - start < count) begin
      r = $urandom_range(99);
      if (r < 6) cal_run(1'b1);
      else if (r < 8) send_word(atp_pkg::CMD_CLEAR, pick16(), pick16(), pick16());
      else if (r < 10) send_word(atp_pkg::CMD_NONE, pick16(), pick16(), pick16());
      else if (r < 14) send_word(atp_pkg::CMD_CAL, pick16(), pick16(), pick16());
      else send_word(atp_pkg::CMD_MEASURE, pick16(), pick16(), pick16());
    end
  endtask

  task automatic test_random_settings(int chunks, int per_chunk);
    for (int c = 0; c < chunks; c++) begin
      write_reg(atp_pkg::REG_MODE, 15'($urandom_range(3)));
      case ($urandom_range(3))
        0: write_reg(atp_pkg::REG_THRESHOLD, 15'd0);
        1: write_reg(atp_pkg::REG_THRESHOLD, 15'h7fff);
        default: write_reg(atp_pkg::REG_THRESHOLD, 15'($urandom_range(4096)));
      endcase
      test_random(per_chunk);
    end
  endtask

  // receiver stalls long while words keep coming, then sender waits for all
  task automatic test_backpressure();
    @(negedge clk_i);
    hold_left = 400;
    for (int i = 0; i < 12; i++)
      send_word(atp_pkg::CMD_MEASURE, pick16(), pick16(), pick16());
    cal_run(1'b0);
    wait (pending_q.size() == 0);
    @(negedge clk_i);
    send_word(atp_pkg::CMD_MEASURE, pick16(), pick16(), pick16());
  endtask

  initial begin
    p_mode = atp_pkg::MODE_AXES; p_thresh = 512;
    p_off_x = 0; p_off_y = 0; p_off_z = 0;
    p_sum_x = 0; p_sum_y = 0; p_sum_z = 0; p_count = 0; p_custom = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    src_idle_pct = 32; snk_idle_pct = 57;
    test_directed();
    test_random_settings(4, 170);
    test_backpressure();
    src_idle_pct = 57; snk_idle_pct = 32;
    test_random_settings(4, 170);
    src_idle_pct = 0; snk_idle_pct = 0;
    test_random_settings(4, 170);
    write_reg(atp_pkg::REG_MODE, 15'(atp_pkg::MODE_DEGREES));
    write_reg(atp_pkg::REG_THRESHOLD, 15'd512);
    test_random(60);

    drain();
    $display("covered %0d words in, %0d results, %0d calibration finishes,",
             words_in, words_out, cal_finishes);
    $display("all display modes, threshold extremes, clear and unused commands, stalls");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule
